// ===== design/xcrc_pkg.sv =====
// Package with types, constants and the CRC helper for the XMODEM-CRC receiver.
`timescale 1ns / 1ps
`default_nettype none
package xcrc_pkg;

	localparam int TIMER_BITS_DEFAULT = 16;
	localparam int SHORT_PACKET_BYTES = 128;
	localparam int LONG_PACKET_BYTES  = 1024;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_BYTE  = 2'd1,
		OP_START = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		PH_HANDSHAKE = 3'd0,
		PH_PACKET    = 3'd1,
		PH_WAIT      = 3'd2,
		PH_DONE      = 3'd3,
		PH_FAIL      = 3'd4
	} phase_t;

	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_HANDSHAKE = 3'd1;
	localparam logic [2:0] ERR_TIMEOUT   = 3'd2;
	localparam logic [2:0] ERR_SEQUENCE  = 3'd3;
	localparam logic [2:0] ERR_CRC       = 3'd4;
	localparam logic [2:0] ERR_RETRIES   = 3'd5;

	localparam logic [1:0] VERDICT_NONE    = 2'd0;
	localparam logic [1:0] VERDICT_COMMIT  = 2'd1;
	localparam logic [1:0] VERDICT_DISCARD = 2'd2;

	localparam logic [2:0] REG_BASE      = 3'd0;
	localparam logic [2:0] REG_BYTE_TO   = 3'd1;
	localparam logic [2:0] REG_WAIT_TO   = 3'd2;
	localparam logic [2:0] REG_MAX_HS    = 3'd3;
	localparam logic [2:0] REG_MAX_RETRY = 3'd4;

	// Classified item handed from the front end to the back end.
	typedef struct packed {
		opcode_t    op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [31:0] data_address;
		logic [1:0]  packet_verdict;
		logic [1:0]  link_state;
		logic [2:0]  error_code;
		logic [31:0] committed_count;
	} result_t;

	// Byte-wise CRC-16 update, polynomial 0x1021, MSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/xcrc_if.sv =====
// Valid/ready stream interfaces for input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface xcrc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;
	modport source (output valid, opcode, rx_byte, input ready);
	modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface xcrc_out_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic [31:0] data_address;
	logic [1:0]  packet_verdict;
	logic [1:0]  link_state;
	logic [2:0]  error_code;
	logic [31:0] committed_count;
	modport source (output valid, tx_valid, tx_byte, data_valid, data_byte, data_address,
		packet_verdict, link_state, error_code, committed_count, input ready);
	modport sink (input valid, tx_valid, tx_byte, data_valid, data_byte, data_address,
		packet_verdict, link_state, error_code, committed_count, output ready);
endinterface
`default_nettype wire

// ===== design/xcrc_front.sv =====
// Front end: accepts input words, drops unused opcodes, queues items for the back end.
`timescale 1ns / 1ps
`default_nettype none
module xcrc_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire         [1:0] in_opcode,
	input  wire         [7:0] in_rx_byte,
	output logic              item_valid,
	input  wire               item_ready,
	output xcrc_pkg::item_t   item
);
	import xcrc_pkg::*;

	// Two-entry queue.
	item_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready && (opcode_t'(in_opcode) != OP_NONE);
	assign item_valid = (count_q != 2'd0);
	assign pop        = item_valid && item_ready;
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: opcode_t'(in_opcode), rx_byte: in_rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== design/xcrc_back.sv =====
// Back end: protocol state, CRC, timers and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module xcrc_back #(
	parameter int TIMER_BITS = xcrc_pkg::TIMER_BITS_DEFAULT
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_ready,
	input  xcrc_pkg::item_t   item,
	input  wire        [31:0] base_address,
	input  wire        [15:0] byte_timeout_ticks,
	input  wire        [15:0] wait_timeout_ticks,
	input  wire         [7:0] max_handshakes,
	input  wire         [7:0] max_retries,
	output logic              res_valid,
	input  wire               res_ready,
	output xcrc_pkg::result_t res
);
	import xcrc_pkg::*;

	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	phase_t          phase_q, phase_d;
	logic [7:0]      exp_seq_q, exp_seq_d;
	logic [15:0]     crc_q, crc_d;
	logic [10:0]     pos_q, pos_d;
	logic            long_q, long_d;
	logic            hdr_bad_q, hdr_bad_d;
	logic [7:0]      seq_q, seq_d;
	logic [7:0]      crc_hi_q, crc_hi_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
	logic [7:0]      hs_q, hs_d, hs_inc;
	logic [7:0]      rt_q, rt_d, rt_inc;
	logic [2:0]      err_q, err_d;
	logic [31:0]     waddr_q, waddr_d;
	logic [31:0]     committed_q, committed_d;

	logic            go, emit;
	result_t         r;
	logic [10:0]     n_bytes;
	logic [15:0]     limit;
	logic            expired;

	assign item_ready = !res_valid || res_ready;
	assign go         = item_valid && item_ready;

	assign timer_inc = (timer_q != TMAX) ? timer_q + 1'b1 : timer_q;
	assign n_bytes   = long_q ? 11'(LONG_PACKET_BYTES) : 11'(SHORT_PACKET_BYTES);
	assign hs_inc    = (hs_q != 8'hFF) ? hs_q + 8'd1 : hs_q;
	assign rt_inc    = (rt_q != 8'hFF) ? rt_q + 8'd1 : rt_q;

	always_comb begin
		limit = (phase_q == PH_PACKET) ? byte_timeout_ticks : wait_timeout_ticks;
		if (TIMER_BITS >= 16) expired = (32'(timer_inc) >= 32'(limit));
		else expired = (32'(timer_inc) >= 32'(limit));
	end

	always_comb begin
		phase_d = phase_q; exp_seq_d = exp_seq_q; crc_d = crc_q; pos_d = pos_q;
		long_d = long_q; hdr_bad_d = hdr_bad_q; seq_d = seq_q; crc_hi_d = crc_hi_q;
		timer_d = timer_q; hs_d = hs_q; rt_d = rt_q; err_d = err_q;
		waddr_d = waddr_q; committed_d = committed_q;
		r = '0;

		unique case (item.op)
			OP_START: begin
				phase_d = PH_HANDSHAKE; exp_seq_d = 8'd1; crc_d = '0; pos_d = '0;
				long_d = 1'b0; hdr_bad_d = 1'b0; seq_d = '0; crc_hi_d = '0;
				timer_d = '0; hs_d = '0; rt_d = '0; err_d = ERR_OK;
				waddr_d = base_address; committed_d = '0;
				r.tx_valid = 1'b1; r.tx_byte = CH_C;
			end
			OP_TICK: begin
				if (phase_q == PH_HANDSHAKE || phase_q == PH_PACKET || phase_q == PH_WAIT) begin
					timer_d = timer_inc;
					if (expired) begin
						if (phase_q == PH_HANDSHAKE) begin
							hs_d = hs_inc;
							if (hs_inc >= max_handshakes) begin
								err_d = ERR_HANDSHAKE; phase_d = PH_FAIL;
								r.tx_valid = 1'b1; r.tx_byte = CH_CAN;
							end else begin
								r.tx_valid = 1'b1; r.tx_byte = CH_C; timer_d = '0;
							end
						end else if (phase_q == PH_WAIT) begin
							err_d = ERR_TIMEOUT; phase_d = PH_FAIL;
							r.tx_valid = 1'b1; r.tx_byte = CH_CAN;
						end else begin
							r.packet_verdict = VERDICT_DISCARD; err_d = ERR_TIMEOUT;
							rt_d = rt_inc;
							if (rt_inc < max_retries) begin
								r.tx_valid = 1'b1; r.tx_byte = CH_NAK;
								phase_d = PH_WAIT; timer_d = '0;
							end else begin
								err_d = ERR_RETRIES; phase_d = PH_FAIL;
								r.tx_valid = 1'b1; r.tx_byte = CH_CAN;
							end
						end
					end
				end
			end
			OP_BYTE: begin
				if ((phase_q == PH_HANDSHAKE || phase_q == PH_WAIT) &&
				    (item.rx_byte == CH_SOH || item.rx_byte == CH_STX)) begin
					long_d = (item.rx_byte == CH_STX); phase_d = PH_PACKET;
					pos_d = '0; crc_d = '0; hdr_bad_d = 1'b0; seq_d = '0;
					crc_hi_d = '0; timer_d = '0;
				end else if (phase_q == PH_WAIT) begin
					if (item.rx_byte == CH_EOT) begin
						r.tx_valid = 1'b1; r.tx_byte = CH_ACK; phase_d = PH_DONE;
					end else begin
						err_d = ERR_SEQUENCE; phase_d = PH_FAIL;
						r.tx_valid = 1'b1; r.tx_byte = CH_CAN;
					end
				end else if (phase_q == PH_PACKET) begin
					timer_d = '0;
					pos_d = pos_q + 11'd1;
					if (pos_q == 11'd0) begin
						seq_d = item.rx_byte;
					end else if (pos_q == 11'd1) begin
						hdr_bad_d = (seq_q != exp_seq_q) || (item.rx_byte != ~seq_q);
					end else if (pos_q < n_bytes + 11'd2) begin
						crc_d = crc_feed(crc_q, item.rx_byte);
						r.data_valid = 1'b1; r.data_byte = item.rx_byte;
						r.data_address = waddr_q + 32'(pos_q - 11'd2);
					end else if (pos_q == n_bytes + 11'd2) begin
						crc_hi_d = item.rx_byte;
					end else begin
						pos_d = pos_q;
						if ({crc_hi_q, item.rx_byte} != crc_q || hdr_bad_q) begin
							r.packet_verdict = VERDICT_DISCARD;
							err_d = ({crc_hi_q, item.rx_byte} != crc_q) ? ERR_CRC : ERR_SEQUENCE;
							rt_d = rt_inc;
							if (rt_inc < max_retries) begin
								r.tx_valid = 1'b1; r.tx_byte = CH_NAK;
								phase_d = PH_WAIT; timer_d = '0;
							end else begin
								err_d = ERR_RETRIES; phase_d = PH_FAIL;
								r.tx_valid = 1'b1; r.tx_byte = CH_CAN;
							end
						end else begin
							r.packet_verdict = VERDICT_COMMIT;
							waddr_d = waddr_q + 32'(n_bytes);
							committed_d = committed_q + 32'(n_bytes);
							exp_seq_d = exp_seq_q + 8'd1; rt_d = '0;
							r.tx_valid = 1'b1; r.tx_byte = CH_ACK;
							phase_d = PH_WAIT; timer_d = '0;
						end
					end
				end
			end
			default: ;
		endcase

		emit = r.tx_valid || r.data_valid || (r.packet_verdict != VERDICT_NONE);
		unique case (phase_d)
			PH_HANDSHAKE: r.link_state = 2'd0;
			PH_PACKET, PH_WAIT: r.link_state = 2'd1;
			PH_DONE: r.link_state = 2'd2;
			default: r.link_state = 2'd3;
		endcase
		r.error_code = err_d;
		r.committed_count = committed_d;
	end

	// Result register; payload carries no reset.
	always_ff @(posedge clk) begin
		if (go && emit) res <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (go) begin
			res_valid <= emit;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// The write address takes base_address only on a start word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HANDSHAKE; exp_seq_q <= 8'd1; crc_q <= '0; pos_q <= '0;
			long_q <= 1'b0; hdr_bad_q <= 1'b0; seq_q <= '0; crc_hi_q <= '0;
			timer_q <= '0; hs_q <= '0; rt_q <= '0; err_q <= ERR_OK;
			waddr_q <= '0; committed_q <= '0;
		end else if (go) begin
			phase_q <= phase_d; exp_seq_q <= exp_seq_d; crc_q <= crc_d; pos_q <= pos_d;
			long_q <= long_d; hdr_bad_q <= hdr_bad_d; seq_q <= seq_d; crc_hi_q <= crc_hi_d;
			timer_q <= timer_d; hs_q <= hs_d; rt_q <= rt_d; err_q <= err_d;
			waddr_q <= waddr_d; committed_q <= committed_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/xmodem_crc_receiver_core.sv =====
// Top level of the XMODEM-CRC receiver: configuration registers, front and back ends.
`timescale 1ns / 1ps
`default_nettype none
// The input channel carries one word per event: a one-millisecond tick, a
// received serial byte, or a start command. The output channel carries a
// word only when the event produced something: a control byte to transmit,
// a payload byte with its flash address, or a packet verdict, together with
// link state, last error and the committed byte count.
// A word can be accepted every cycle while the output receiver does not
// stall. An accepted word is written into the front queue and passes from
// there through the back end into the registered result stage. The
// byte-wise CRC update is combinational within the back end.
// Reset clears the queue and the result valid flag and puts the receiver in
// the handshake phase with default timeouts and limits. When the output
// receiver stalls, the result register holds its word, the back end stops,
// and the front queue absorbs up to two more input words before ready drops.
// Configuration writes are taken whenever the write enable is high and
// should occur only while idle.
module xmodem_crc_receiver_core #(
	parameter int TIMER_BITS = xcrc_pkg::TIMER_BITS_DEFAULT
) (
	input  wire        clk,
	input  wire        arst_n,
	xcrc_in_if.sink    in_ch,
	xcrc_out_if.source out_ch,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [31:0] cfg_data
);
	import xcrc_pkg::*;

	logic [31:0] base_address_q;
	logic [15:0] byte_to_q, wait_to_q;
	logic [7:0]  max_hs_q, max_rt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			byte_to_q      <= 16'd1000;
			wait_to_q      <= 16'd3000;
			max_hs_q       <= 8'd10;
			max_rt_q       <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:      base_address_q <= cfg_data;
				REG_BYTE_TO:   byte_to_q <= cfg_data[15:0];
				REG_WAIT_TO:   wait_to_q <= cfg_data[15:0];
				REG_MAX_HS:    max_hs_q <= cfg_data[7:0];
				REG_MAX_RETRY: max_rt_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	item_t   item;
	logic    item_valid, item_ready;
	result_t res;

	xcrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_opcode  (in_ch.opcode),
		.in_rx_byte (in_ch.rx_byte),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	xcrc_back #(.TIMER_BITS(TIMER_BITS)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_ready         (item_ready),
		.item               (item),
		.base_address       (base_address_q),
		.byte_timeout_ticks (byte_to_q),
		.wait_timeout_ticks (wait_to_q),
		.max_handshakes     (max_hs_q),
		.max_retries        (max_rt_q),
		.res_valid          (out_ch.valid),
		.res_ready          (out_ch.ready),
		.res                (res)
	);

	assign out_ch.tx_valid        = res.tx_valid;
	assign out_ch.tx_byte         = res.tx_byte;
	assign out_ch.data_valid      = res.data_valid;
	assign out_ch.data_byte       = res.data_byte;
	assign out_ch.data_address    = res.data_address;
	assign out_ch.packet_verdict  = res.packet_verdict;
	assign out_ch.link_state      = res.link_state;
	assign out_ch.error_code      = res.error_code;
	assign out_ch.committed_count = res.committed_count;
endmodule
`default_nettype wire

// ===== test/xmodem_crc_receiver_core_tb.sv =====
// Self-checking testbench for the XMODEM-CRC receiver core with a built-in receiver predictor.
`timescale 1ns / 1ps
module xmodem_crc_receiver_core_tb;
	import xcrc_pkg::*;

	// Cycles with no word moving on either channel before the run is declared hung.
	// The slowest legal gap is a sender gap plus a receiver stall plus the pipeline.
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1650;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	xcrc_in_if  in_ch ();
	xcrc_out_if out_ch ();

	xmodem_crc_receiver_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Register copies as the receiver should hold them.
	logic [31:0] r_base;
	logic [15:0] r_byte_to;
	logic [15:0] r_wait_to;
	logic [7:0]  r_max_hs;
	logic [7:0]  r_max_retry;

	// Receiver state as the predictor tracks it.
	phase_t      ph;
	logic [7:0]  exp_seq;
	logic [15:0] crc_acc;
	logic [10:0] pos;
	logic        is_long;
	logic        hdr_bad;
	logic [7:0]  seq_hold;
	logic [7:0]  crc_hi;
	logic [15:0] ticks;
	logic [7:0]  hs_tries;
	logic [7:0]  nak_tries;
	logic [2:0]  err_last;
	logic [31:0] wr_addr;
	logic [31:0] committed;

	// Results still owed by the receiver, oldest first.
	result_t owed_results[$];

	int errors;
	int words_sent;
	int idle_cycles;
	int stall_left;
	bit burst_in;
	bit burst_out;
	bit long_done;

	typedef struct {
		opcode_t    op;
		logic [7:0] b;
		bit         typed;
		bit         has;
		result_t    r;
	} row_t;

	row_t rows[$];

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	function automatic result_t mk(input logic txv, input logic [7:0] txb, input logic dv,
		input logic [7:0] db, input logic [31:0] addr, input logic [1:0] verdict,
		input logic [1:0] link, input logic [2:0] err, input logic [31:0] cnt);
		result_t r;
		r.tx_valid = txv;
		r.tx_byte = txb;
		r.data_valid = dv;
		r.data_byte = db;
		r.data_address = addr;
		r.packet_verdict = verdict;
		r.link_state = link;
		r.error_code = err;
		r.committed_count = cnt;
		return r;
	endfunction

	function automatic void restart_link();
		ph = PH_HANDSHAKE;
		exp_seq = 8'd1;
		crc_acc = '0;
		pos = '0;
		is_long = 1'b0;
		hdr_bad = 1'b0;
		seq_hold = '0;
		crc_hi = '0;
		ticks = '0;
		hs_tries = '0;
		nak_tries = '0;
		err_last = ERR_OK;
		wr_addr = r_base;
		committed = '0;
	endfunction

	// The tick timer saturates at its width; the timeout fires once it reaches the limit.
	function automatic bit tick_expired(input logic [15:0] limit);
		if (ticks != 16'hFFFF)
			ticks = ticks + 16'd1;
		return ticks >= limit;
	endfunction

	function automatic void open_packet(input logic [7:0] b);
		is_long = (b == CH_STX);
		ph = PH_PACKET;
		pos = '0;
		crc_acc = '0;
		hdr_bad = 1'b0;
		seq_hold = '0;
		crc_hi = '0;
		ticks = '0;
	endfunction

	function automatic void abort_link(input logic [2:0] code, inout result_t r);
		err_last = code;
		ph = PH_FAIL;
		r.tx_valid = 1'b1;
		r.tx_byte = CH_CAN;
	endfunction

	// A rejected packet is discarded; NAK while retries remain, otherwise cancel.
	function automatic void reject_packet(input logic [2:0] code, inout result_t r);
		r.packet_verdict = VERDICT_DISCARD;
		err_last = code;
		if (nak_tries != 8'hFF)
			nak_tries = nak_tries + 8'd1;
		if (nak_tries < r_max_retry) begin
			r.tx_valid = 1'b1;
			r.tx_byte = CH_NAK;
			ph = PH_WAIT;
			ticks = '0;
		end else begin
			abort_link(ERR_RETRIES, r);
		end
	endfunction

	function automatic void take_packet_byte(input logic [7:0] b, inout result_t r);
		logic [10:0] n;
		n = is_long ? 11'd1024 : 11'd128;
		ticks = '0;
		if (pos == 11'd0) begin
			seq_hold = b;
		end else if (pos == 11'd1) begin
			hdr_bad = (seq_hold != exp_seq) || (b != ~seq_hold);
		end else if (pos < n + 11'd2) begin
			crc_acc = crc_step(crc_acc, b);
			r.data_valid = 1'b1;
			r.data_byte = b;
			r.data_address = wr_addr + 32'(pos - 11'd2);
		end else if (pos == n + 11'd2) begin
			crc_hi = b;
		end else begin
			if ({crc_hi, b} != crc_acc) begin
				reject_packet(ERR_CRC, r);
			end else if (hdr_bad) begin
				reject_packet(ERR_SEQUENCE, r);
			end else begin
				r.packet_verdict = VERDICT_COMMIT;
				wr_addr = wr_addr + 32'(n);
				committed = committed + 32'(n);
				exp_seq = exp_seq + 8'd1;
				nak_tries = '0;
				r.tx_valid = 1'b1;
				r.tx_byte = CH_ACK;
				ph = PH_WAIT;
				ticks = '0;
			end
			return;
		end
		pos = pos + 11'd1;
	endfunction

	// Advances the predicted receiver by one input word; returns 1 when a result is due.
	function automatic bit predict_word(input opcode_t op, input logic [7:0] b,
		output result_t r);
		r = mk(0, 0, 0, 0, 0, VERDICT_NONE, 0, 0, 0);
		case (op)
			OP_START: begin
				restart_link();
				r.tx_valid = 1'b1;
				r.tx_byte = CH_C;
			end
			OP_TICK: begin
				if (ph == PH_HANDSHAKE) begin
					if (tick_expired(r_wait_to)) begin
						if (hs_tries != 8'hFF)
							hs_tries = hs_tries + 8'd1;
						if (hs_tries >= r_max_hs) begin
							abort_link(ERR_HANDSHAKE, r);
						end else begin
							r.tx_valid = 1'b1;
							r.tx_byte = CH_C;
							ticks = '0;
						end
					end
				end else if (ph == PH_PACKET) begin
					if (tick_expired(r_byte_to))
						reject_packet(ERR_TIMEOUT, r);
				end else if (ph == PH_WAIT) begin
					if (tick_expired(r_wait_to))
						abort_link(ERR_TIMEOUT, r);
				end
			end
			OP_BYTE: begin
				if (ph == PH_HANDSHAKE) begin
					if (b == CH_SOH || b == CH_STX)
						open_packet(b);
				end else if (ph == PH_PACKET) begin
					take_packet_byte(b, r);
				end else if (ph == PH_WAIT) begin
					if (b == CH_EOT) begin
						r.tx_valid = 1'b1;
						r.tx_byte = CH_ACK;
						ph = PH_DONE;
					end else if (b == CH_SOH || b == CH_STX) begin
						open_packet(b);
					end else begin
						abort_link(ERR_SEQUENCE, r);
					end
				end
			end
			default: begin
				// The unused opcode is dropped without a result.
			end
		endcase
		if (!r.tx_valid && !r.data_valid && r.packet_verdict == VERDICT_NONE)
			return 1'b0;
		case (ph)
			PH_HANDSHAKE: r.link_state = 2'd0;
			PH_PACKET, PH_WAIT: r.link_state = 2'd1;
			PH_DONE: r.link_state = 2'd2;
			default: r.link_state = 2'd3;
		endcase
		r.error_code = err_last;
		r.committed_count = committed;
		return 1'b1;
	endfunction

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
		errors++;
	endtask

	// Sends one word after a random gap and, once it is taken, records what it should cause.
	// A typed row replaces the predicted result with the one written in the table.
	task automatic send_word(input opcode_t op, input logic [7:0] b, input bit typed = 0,
		input bit has = 0, input result_t want = '0);
		int gap;
		result_t r;
		bit got;
		gap = burst_in ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.opcode = op;
		in_ch.rx_byte = b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		got = predict_word(op, b, r);
		if (typed ? has : got)
			owed_results.push_back(typed ? want : r);
		words_sent++;
		@(negedge clk);
	endtask

	// Holds the sender off until every owed result has come, then lets the pipeline settle.
	task automatic drain();
		in_ch.valid = 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BASE: r_base = value;
			REG_BYTE_TO: r_byte_to = value[15:0];
			REG_WAIT_TO: r_wait_to = value[15:0];
			REG_MAX_HS: r_max_hs = value[7:0];
			REG_MAX_RETRY: r_max_retry = value[7:0];
			default: begin
				// Indexes beyond the last register are ignored by the receiver.
			end
		endcase
	endtask

	task automatic configure(input logic [31:0] base, input logic [15:0] byte_to,
		input logic [15:0] wait_to, input logic [7:0] max_hs, input logic [7:0] max_retry);
		drain();
		write_reg(REG_BASE, base);
		write_reg(REG_BYTE_TO, {16'd0, byte_to});
		write_reg(REG_WAIT_TO, {16'd0, wait_to});
		write_reg(REG_MAX_HS, {24'd0, max_hs});
		write_reg(REG_MAX_RETRY, {24'd0, max_retry});
	endtask

	// One transfer: start, handshake noise, a few packets (mostly well formed), then an ending.
	task automatic run_session(input bit force_long);
		int npk;
		int len;
		int cut;
		int guard;
		bit bad_crc;
		logic [7:0] d;
		logic [7:0] seq;
		logic [15:0] crc;
		send_word(OP_START, 8'h00);
		repeat ($urandom_range(0, 3)) begin
			d = $urandom;
			if (d == CH_SOH || d == CH_STX)
				d = 8'hA5;
			case ($urandom_range(0, 2))
				0: send_word(OP_TICK, $urandom);
				1: send_word(OP_BYTE, d);
				default: send_word(OP_NONE, $urandom);
			endcase
		end
		// Sometimes let the handshake run out of attempts.
		if (!force_long && $urandom_range(0, 5) == 0) begin
			guard = 0;
			while (ph == PH_HANDSHAKE && guard < 40) begin
				send_word(OP_TICK, $urandom);
				guard++;
			end
		end
		npk = $urandom_range(1, 4);
		for (int k = 0; k < npk; k++) begin
			if (ph != PH_HANDSHAKE && ph != PH_WAIT)
				break;
			// Stop opening packets once the word budget is spent.
			if (!force_long && words_sent >= RANDOM_WORDS)
				break;
			len = (force_long && k == 0) ? LONG_PACKET_BYTES : SHORT_PACKET_BYTES;
			send_word(OP_BYTE, (len == LONG_PACKET_BYTES) ? CH_STX : CH_SOH);
			seq = ($urandom_range(0, 7) == 0) ? 8'($urandom) : exp_seq;
			send_word(OP_BYTE, seq);
			send_word(OP_BYTE, ($urandom_range(0, 9) == 0) ? 8'($urandom) : ~seq);
			cut = (r_byte_to <= 20 && !force_long && $urandom_range(0, 14) == 0) ?
				$urandom_range(0, len + 1) : -1;
			bad_crc = ($urandom_range(0, 9) == 0);
			crc = '0;
			for (int p = 0; p < len + 2; p++) begin
				if (p == cut)
					break;
				if (r_byte_to > 1 && $urandom_range(0, 40) == 0)
					send_word(OP_TICK, $urandom);
				if (p < len) begin
					d = $urandom;
					crc = crc_step(crc, d);
				end else if (p == len) begin
					d = crc[15:8];
				end else begin
					d = crc[7:0] ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00);
				end
				send_word(OP_BYTE, d);
			end
			// A cut packet is left to time out byte by byte.
			if (cut >= 0) begin
				while (ph == PH_PACKET)
					send_word(OP_TICK, $urandom);
			end
			if (ph == PH_WAIT && r_wait_to > 1 && $urandom_range(0, 3) == 0)
				send_word(OP_TICK, $urandom);
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		if (ph == PH_WAIT) begin
			case ($urandom_range(0, 6))
				0: begin
					d = $urandom;
					if (d == CH_SOH || d == CH_STX || d == CH_EOT)
						d = 8'hFF;
					send_word(OP_BYTE, d);
				end
				1: begin
					if (r_wait_to <= 20) begin
						while (ph == PH_WAIT)
							send_word(OP_TICK, $urandom);
					end else begin
						send_word(OP_BYTE, CH_EOT);
					end
				end
				default: send_word(OP_BYTE, CH_EOT);
			endcase
		end
		// Words after the end of a transfer must be ignored.
		repeat ($urandom_range(0, 2))
			send_word(($urandom_range(0, 1) == 0) ? OP_TICK : OP_BYTE, $urandom);
	endtask

	// Result checker and hang watchdog, both on the rising edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			stall_left = burst_out ? 0 : $urandom_range(0, 17);
			if (owed_results.size() == 0) begin
				$display("unexpected word at %0t", $realtime);
				errors++;
			end else begin
				want = owed_results.pop_front();
				if (out_ch.tx_valid !== want.tx_valid)
					report("tx_valid", out_ch.tx_valid, want.tx_valid);
				if (out_ch.tx_byte !== want.tx_byte)
					report("tx_byte", out_ch.tx_byte, want.tx_byte);
				if (out_ch.data_valid !== want.data_valid)
					report("data_valid", out_ch.data_valid, want.data_valid);
				if (out_ch.data_byte !== want.data_byte)
					report("data_byte", out_ch.data_byte, want.data_byte);
				if (out_ch.data_address !== want.data_address)
					report("data_address", out_ch.data_address, want.data_address);
				if (out_ch.packet_verdict !== want.packet_verdict)
					report("packet_verdict", out_ch.packet_verdict, want.packet_verdict);
				if (out_ch.link_state !== want.link_state)
					report("link_state", out_ch.link_state, want.link_state);
				if (out_ch.error_code !== want.error_code)
					report("error_code", out_ch.error_code, want.error_code);
				if (out_ch.committed_count !== want.committed_count)
					report("committed_count", out_ch.committed_count, want.committed_count);
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("xmodem_crc_receiver_core_tb: errors");
				$finish;
			end
		end
	end

	// The result side stalls for the drawn number of cycles after each word it takes.
	always @(negedge clk) begin
		out_ch.ready = (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	initial begin
		result_t none;
		int cfg_round;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_TICK;
		in_ch.rx_byte = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		words_sent = 0;
		idle_cycles = 0;
		stall_left = 0;
		burst_in = 0;
		burst_out = 0;
		long_done = 0;
		r_base = '0;
		r_byte_to = 16'd1000;
		r_wait_to = 16'd3000;
		r_max_hs = 8'd10;
		r_max_retry = 8'd10;
		restart_link();
		none = mk(0, 0, 0, 0, 0, VERDICT_NONE, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: timeouts of one tick, low limits, base at the top of the address space
		// so that the second payload byte wraps to zero.
		configure(32'hFFFF_FFFF, 16'd1, 16'd1, 8'd2, 8'd1);
		write_reg(3'd5, 32'hFFFF_FFFF);
		rows = '{
			'{OP_START, 8'h00, 1, 1, mk(1, CH_C, 0, 0, 0, VERDICT_NONE, 0, ERR_OK, 0)},
			'{OP_NONE, 8'hFF, 1, 0, none},
			'{OP_TICK, 8'h00, 1, 1, mk(1, CH_C, 0, 0, 0, VERDICT_NONE, 0, ERR_OK, 0)},
			'{OP_TICK, 8'h00, 1, 1,
				mk(1, CH_CAN, 0, 0, 0, VERDICT_NONE, 3, ERR_HANDSHAKE, 0)},
			'{OP_BYTE, CH_SOH, 1, 0, none},
			'{OP_START, 8'hFF, 1, 1, mk(1, CH_C, 0, 0, 0, VERDICT_NONE, 0, ERR_OK, 0)},
			'{OP_BYTE, 8'h55, 1, 0, none},
			'{OP_BYTE, CH_STX, 1, 0, none},
			'{OP_BYTE, 8'h01, 1, 0, none},
			'{OP_BYTE, 8'hFE, 1, 0, none},
			'{OP_BYTE, 8'hFF, 1, 1,
				mk(0, 0, 1, 8'hFF, 32'hFFFF_FFFF, VERDICT_NONE, 1, ERR_OK, 0)},
			'{OP_BYTE, 8'h00, 1, 1, mk(0, 0, 1, 8'h00, 32'h0, VERDICT_NONE, 1, ERR_OK, 0)},
			'{OP_BYTE, 8'hAA, 0, 0, none},
			'{OP_TICK, 8'h00, 1, 1,
				mk(1, CH_CAN, 0, 0, 0, VERDICT_DISCARD, 3, ERR_RETRIES, 0)},
			'{OP_START, 8'h00, 1, 1, mk(1, CH_C, 0, 0, 0, VERDICT_NONE, 0, ERR_OK, 0)},
			'{OP_BYTE, CH_SOH, 0, 0, none},
			'{OP_BYTE, 8'h00, 0, 0, none},
			'{OP_BYTE, 8'hFF, 0, 0, none},
			'{OP_BYTE, 8'h80, 0, 0, none},
			'{OP_TICK, 8'h00, 1, 1,
				mk(1, CH_CAN, 0, 0, 0, VERDICT_DISCARD, 3, ERR_RETRIES, 0)},
			'{OP_TICK, 8'h00, 1, 0, none}
		};
		foreach (rows[i])
			send_word(rows[i].op, rows[i].b, rows[i].typed, rows[i].has, rows[i].r);

		// Random part: several register settings in turn, the extremes among them.
		// The round with the long packet comes first so that it always runs.
		words_sent = 0;
		cfg_round = 2;
		while (words_sent < RANDOM_WORDS) begin
			case (cfg_round % 4)
				0: configure($urandom, 16'd4, 16'd6, 8'd3, 8'd3);
				1: configure(32'hFFFF_FF00, 16'd1, 16'd1, 8'd1, 8'd1);
				2: configure(32'h0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
				default: configure($urandom, 16'($urandom_range(2, 8)),
					16'($urandom_range(2, 10)), 8'($urandom_range(1, 5)),
					8'($urandom_range(1, 4)));
			endcase
			repeat ($urandom_range(2, 3)) begin
				if (words_sent < RANDOM_WORDS) begin
					burst_in = ($urandom_range(0, 4) == 0);
					burst_out = ($urandom_range(0, 4) == 0);
					run_session(cfg_round % 4 == 2 && !long_done);
					if (cfg_round % 4 == 2)
						long_done = 1;
				end
			end
			cfg_round++;
		end

		drain();
		if (errors == 0) begin
			$display("xmodem_crc_receiver_core_tb: clean");
		end else begin
			$display("xmodem_crc_receiver_core_tb: errors");
		end
		$finish;
	end

endmodule
